### src/mceg_pkg.sv
`timescale 1ns / 1ps

package mceg_pkg;

    // Default depth of the queue between front and back
    localparam int QueueDepth = 2;

    // Event kind codes
    localparam logic [1:0] KIND_DX   = 2'd0;
    localparam logic [1:0] KIND_DY   = 2'd1;
    localparam logic [1:0] KIND_DOWN = 2'd2;
    localparam logic [1:0] KIND_UP   = 2'd3;

    // Button ids carried in event_value
    localparam logic signed [7:0] BTN_ID_LEFT  = 8'sd0;
    localparam logic signed [7:0] BTN_ID_RIGHT = 8'sd1;

    // Bit positions in the pending event mask, in emission order
    localparam int EV_DX    = 0;
    localparam int EV_DY    = 1;
    localparam int EV_LEFT  = 2;
    localparam int EV_RIGHT = 3;
    localparam int EV_COUNT = 4;

    // One input beat
    typedef struct packed {
        logic [7:0] x_count;
        logic [7:0] y_count;
        logic       left_pin_n;
        logic       right_pin_n;
    } tick_t;

    // One output beat
    typedef struct packed {
        logic [1:0]        event_kind;
        logic signed [7:0] event_value;
        logic              last_event;
    } evt_t;

    // Classified tick, handed from front to back
    typedef struct packed {
        logic [7:0]          dx;
        logic [7:0]          dy;
        logic [EV_COUNT-1:0] mask;
        logic                left_down;
        logic                right_down;
    } work_t;

    // Queue write side as seen by the front
    typedef struct packed {
        logic  push;
        work_t data;
    } qwr_t;

    // Queue read side as seen by the back
    typedef struct packed {
        logic  empty;
        work_t data;
    } qrd_t;

endpackage

### src/mceg_front.sv
`timescale 1ns / 1ps

module mceg_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tick_valid,
    output logic               tick_stall,
    input  mceg_pkg::tick_t    tick,
    input  logic               full,
    output mceg_pkg::qwr_t     qwr
);

    logic [7:0] last_x_reg;
    logic [7:0] last_x_next;
    logic [7:0] last_y_reg;
    logic [7:0] last_y_next;
    logic [1:0] last_buttons_reg;
    logic [1:0] last_buttons_next;
    logic       primed_reg;
    logic       primed_next;

    logic                          accept;
    logic [1:0]                    buttons;
    logic [1:0]                    change;
    logic [7:0]                    dx;
    logic [7:0]                    dy;
    logic [mceg_pkg::EV_COUNT-1:0] mask;

    // Hold off the source while the queue has no room
    assign tick_stall = full;
    assign accept     = tick_valid && !full;

    // Classify the tick against the stored state
    always_comb
    begin
        buttons = {~tick.right_pin_n, ~tick.left_pin_n};
        change  = buttons ^ last_buttons_reg;
        dx      = tick.x_count - last_x_reg;
        dy      = tick.y_count - last_y_reg;
        mask    = '0;
        mask[mceg_pkg::EV_DX]    = (dx != 8'd0);
        mask[mceg_pkg::EV_DY]    = (dy != 8'd0);
        mask[mceg_pkg::EV_LEFT]  = change[0];
        mask[mceg_pkg::EV_RIGHT] = change[1];
    end

    // Push only ticks that cause at least one event
    always_comb
    begin
        qwr.push            = accept && primed_reg && (mask != '0);
        qwr.data.dx         = dx;
        qwr.data.dy         = dy;
        qwr.data.mask       = mask;
        qwr.data.left_down  = buttons[0];
        qwr.data.right_down = buttons[1];
    end

    // Capture the tick as the new reference
    always_comb
    begin
        last_x_next       = last_x_reg;
        last_y_next       = last_y_reg;
        last_buttons_next = last_buttons_reg;
        primed_next       = primed_reg;
        if (accept)
        begin
            last_x_next       = tick.x_count;
            last_y_next       = tick.y_count;
            last_buttons_next = buttons;
            primed_next       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg       <= '0;
            last_y_reg       <= '0;
            last_buttons_reg <= '0;
            primed_reg       <= 1'b0;
        end
        else
        begin
            last_x_reg       <= last_x_next;
            last_y_reg       <= last_y_next;
            last_buttons_reg <= last_buttons_next;
            primed_reg       <= primed_next;
        end
    end

endmodule

### src/mceg_queue.sv
`timescale 1ns / 1ps

module mceg_queue
#(
    parameter int DEPTH = mceg_pkg::QueueDepth
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  mceg_pkg::qwr_t qwr,
    output logic           full,
    input  logic           pop,
    output mceg_pkg::qrd_t qrd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mceg_pkg::work_t slot_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign qrd.empty = (count_reg == '0);
    assign qrd.data  = slot_reg[rd_ptr_reg];

    assign do_push = qwr.push && !full;
    assign do_pop  = pop && !qrd.empty;

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Store the pushed descriptor
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= qwr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### src/mceg_back.sv
`timescale 1ns / 1ps

module mceg_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  mceg_pkg::qrd_t qrd,
    output logic           pop,
    output logic           evt_valid,
    input  logic           evt_stall,
    output mceg_pkg::evt_t evt
);

    mceg_pkg::work_t               work_reg;
    mceg_pkg::work_t               work_next;
    logic [mceg_pkg::EV_COUNT-1:0] rem_reg;
    logic [mceg_pkg::EV_COUNT-1:0] rem_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    mceg_pkg::evt_t                evt_reg;
    mceg_pkg::evt_t                evt_next;

    logic                          advance;
    logic                          busy;
    logic                          emit;
    logic [mceg_pkg::EV_COUNT-1:0] sel;
    logic [mceg_pkg::EV_COUNT-1:0] rem_after;
    mceg_pkg::evt_t                cur;

    assign advance   = !out_valid_reg || !evt_stall;
    assign busy      = (rem_reg != '0);
    assign emit      = advance && busy;
    assign rem_after = rem_reg & ~sel;

    // Fetch the next descriptor as the current one runs out
    assign pop = !qrd.empty && (!busy || (emit && (rem_after == '0)));

    // Pick the earliest pending event and build its beat
    always_comb
    begin
        sel             = '0;
        cur.event_kind  = mceg_pkg::KIND_DX;
        cur.event_value = work_reg.dx;
        if (rem_reg[mceg_pkg::EV_DX])
        begin
            sel[mceg_pkg::EV_DX] = 1'b1;
        end
        else if (rem_reg[mceg_pkg::EV_DY])
        begin
            sel[mceg_pkg::EV_DY] = 1'b1;
            cur.event_kind       = mceg_pkg::KIND_DY;
            cur.event_value      = work_reg.dy;
        end
        else if (rem_reg[mceg_pkg::EV_LEFT])
        begin
            sel[mceg_pkg::EV_LEFT] = 1'b1;
            cur.event_kind  = work_reg.left_down ? mceg_pkg::KIND_DOWN : mceg_pkg::KIND_UP;
            cur.event_value = mceg_pkg::BTN_ID_LEFT;
        end
        else
        begin
            sel[mceg_pkg::EV_RIGHT] = 1'b1;
            cur.event_kind  = work_reg.right_down ? mceg_pkg::KIND_DOWN : mceg_pkg::KIND_UP;
            cur.event_value = mceg_pkg::BTN_ID_RIGHT;
        end
        cur.last_event = (rem_after == '0);
    end

    // Retire the emitted event and load new work
    always_comb
    begin
        work_next      = work_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg;
        evt_next       = evt_reg;
        if (emit)
        begin
            rem_next = rem_after;
            evt_next = cur;
        end
        if (pop)
        begin
            work_next = qrd.data;
            rem_next  = qrd.data.mask;
        end
        if (advance)
        begin
            out_valid_next = emit;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        evt_reg  <= evt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign evt_valid = out_valid_reg;
    assign evt       = evt_reg;

endmodule

### src/mouse_counter_event_generator_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake               Payload
// tick      in         tick_valid/tick_stall   mceg_pkg::tick_t
// evt       out        evt_valid/evt_stall     mceg_pkg::evt_t
//
// A tick is taken whenever the descriptor queue has room; the
// front classifies it and queues up to four pending events.
// The back emits one event per cycle from a registered output unless stalled,
// so a tick holds the back until its events (four at most) are out; the back
// sets the rate. First events pass the queue, work and output registers.
// Reset clears the stored counters, the queue and the output; the first tick
// after reset only seeds the stored values.
// An output stall holds the beat; the queue fills and then stalls the input.

module mouse_counter_event_generator_unit
#(
    parameter int QUEUE_DEPTH = mceg_pkg::QueueDepth
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            tick_valid,
    output logic            tick_stall,
    input  mceg_pkg::tick_t tick,
    output logic            evt_valid,
    input  logic            evt_stall,
    output mceg_pkg::evt_t  evt
);

    mceg_pkg::qwr_t qwr;
    mceg_pkg::qrd_t qrd;
    logic           full;
    logic           pop;

    mceg_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_stall (tick_stall),
        .tick       (tick),
        .full       (full),
        .qwr        (qwr)
    );

    mceg_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .qwr   (qwr),
        .full  (full),
        .pop   (pop),
        .qrd   (qrd)
    );

    mceg_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .qrd       (qrd),
        .pop       (pop),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt)
    );

endmodule

### src/mceg_checker.sv
`timescale 1ns / 1ps

module mceg_checker
(
    input logic            clk,
    input logic            rst_n,
    input logic            evt_valid,
    input logic            evt_stall,
    input mceg_pkg::evt_t  evt
);

    // Hold a stalled beat
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_stall |=> evt_valid && $stable(evt))
    else $error("stalled event beat changed");

    // Follow a non-final event with the rest of its tick at once
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_stall && !evt.last_event |=> evt_valid)
    else $error("gap inside the events of one tick");

    // Never report a zero move
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && (evt.event_kind == mceg_pkg::KIND_DX ||
                      evt.event_kind == mceg_pkg::KIND_DY)
        |-> evt.event_value != 8'sd0)
    else $error("move event with zero delta");

    // Keep the order within a tick: no X move after a Y move
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_stall && !evt.last_event &&
        evt.event_kind == mceg_pkg::KIND_DY
        |=> evt.event_kind != mceg_pkg::KIND_DX && evt.event_kind != mceg_pkg::KIND_DY)
    else $error("event order broken inside a tick");

    // Carry only a known button id on button events
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && (evt.event_kind == mceg_pkg::KIND_DOWN ||
                      evt.event_kind == mceg_pkg::KIND_UP)
        |-> evt.event_value == mceg_pkg::BTN_ID_LEFT ||
            evt.event_value == mceg_pkg::BTN_ID_RIGHT)
    else $error("button event with unknown id");

endmodule

bind mouse_counter_event_generator_unit mceg_checker u_mceg_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .evt_valid  (evt_valid),
    .evt_stall  (evt_stall),
    .evt        (evt)
);
